// File: hw/rtl/ssq_pkg.sv
package ssq_pkg;

    localparam int MAX_SAMPLES_DEF = 64;
    localparam int DATA_W          = 32;
    localparam int COUNT_OUT_W     = 7;
    localparam int FRAC_W          = 7;
    localparam int PROD_W          = FRAC_W + DATA_W;
    localparam int HUNDRED         = 100;
    localparam int FIFO_DEPTH      = 4;
    localparam int NUM_Q           = 4;

    // Percentile points in hundredths: 10th, 50th, 90th and 95th.
    localparam logic [FRAC_W-1:0] PCT [NUM_Q] = '{7'd10, 7'd50, 7'd90, 7'd95};

    typedef enum logic [1:0] {
        K_CLOSE_ONLY = 2'd0,
        K_INSERT     = 2'd1,
        K_NON_FINITE = 2'd2,
        K_OVERFLOW   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NON_FINITE = 2'd1,
        ST_OVERFLOW   = 2'd2
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic               last;
        logic [DATA_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    typedef enum logic [3:0] {
        B_IDLE,
        B_EXEC,
        B_INS_CMP,
        B_INS_WR,
        B_CLOSE,
        B_MIN,
        B_MAX,
        B_Q_NUM,
        B_Q_DIV1,
        B_Q_LO,
        B_Q_HI,
        B_Q_DIV2S,
        B_Q_DIV2,
        B_OUT
    } t_bstate;

endpackage

// File: hw/rtl/ssq_fifo.sv
module ssq_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ssq_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output ssq_pkg::t_cmd     o_head,
    output ssq_pkg::t_q_flags o_flags
);

    localparam int PW = $clog2(ssq_pkg::FIFO_DEPTH);
    localparam int LW = $clog2(ssq_pkg::FIFO_DEPTH + 1);

    ssq_pkg::t_cmd  r_entries [ssq_pkg::FIFO_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [LW-1:0]  r_level;
    logic           do_push;
    logic           do_pop;

    assign do_push = i_push && !o_flags.full;
    assign do_pop  = i_pop && !o_flags.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_level <= r_level + 1'b1;
            end else if (do_pop && !do_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entries[r_wp] <= i_cmd;
        end
    end

    assign o_head        = r_entries[r_rp];
    assign o_flags.full  = (r_level == LW'(ssq_pkg::FIFO_DEPTH));
    assign o_flags.empty = (r_level == '0);

endmodule

// File: hw/rtl/ssq_front.sv
module ssq_front #(
    parameter int MAX_SAMPLES = ssq_pkg::MAX_SAMPLES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_has_sample,
    input  logic [ssq_pkg::DATA_W-1:0] i_sample_value,
    input  logic                       i_sample_not_finite,
    input  logic                       i_last_of_set,
    input  ssq_pkg::t_q_flags          i_q_flags,
    output logic                       o_busy,
    output logic                       o_push,
    output ssq_pkg::t_cmd              o_cmd
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);

    logic [CW-1:0]  r_fcount;
    logic [CW-1:0]  n_fcount;
    logic           accept;
    ssq_pkg::t_kind kind;

    assign o_busy = i_q_flags.full;
    assign accept = i_start && !o_busy;

    always_comb begin
        if (!i_has_sample) begin
            kind = ssq_pkg::K_CLOSE_ONLY;
        end else if (i_sample_not_finite) begin
            kind = ssq_pkg::K_NON_FINITE;
        end else if (r_fcount >= CW'(MAX_SAMPLES)) begin
            kind = ssq_pkg::K_OVERFLOW;
        end else begin
            kind = ssq_pkg::K_INSERT;
        end
    end

    always_comb begin
        n_fcount = r_fcount;
        if (accept && i_last_of_set) begin
            n_fcount = '0;
        end else if (accept && kind == ssq_pkg::K_INSERT) begin
            n_fcount = r_fcount + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcount <= '0;
        end else begin
            r_fcount <= n_fcount;
        end
    end

    assign o_push      = accept && (i_has_sample || i_last_of_set);
    assign o_cmd.kind  = kind;
    assign o_cmd.last  = i_last_of_set;
    assign o_cmd.value = i_sample_value;

endmodule

// File: hw/rtl/ssq_div100.sv
module ssq_div100 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ssq_pkg::PROD_W-1:0] i_dividend,
    output logic                       o_done,
    output logic [ssq_pkg::PROD_W-1:0] o_quotient,
    output logic [ssq_pkg::FRAC_W-1:0] o_remainder
);

    localparam int W  = ssq_pkg::PROD_W;
    localparam int RW = ssq_pkg::FRAC_W;
    localparam int LW = 16;
    localparam int GW = W - LW;
    localparam int SH = 30;
    localparam int MW = 24;
    localparam int XW = GW + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(ssq_pkg::HUNDRED - 1)) / 64'(ssq_pkg::HUNDRED));

    logic [3:0]    r_phase;
    logic          r_done;
    logic [GW-1:0] r_digit;
    logic [LW-1:0] r_low;
    logic [XW-1:0] r_prod;
    logic [GW-1:0] r_qh;
    logic [LW-1:0] r_ql;
    logic [RW-1:0] r_rem;
    logic [GW-1:0] q_digit;
    logic [GW-1:0] rem_full;
    logic [RW-1:0] rem_digit;

    // The dividend is divided as two digits: the upper bits first, then the remainder joined
    // with the lower sixteen bits. Each digit is below 2^23, where the reciprocal is exact.
    assign q_digit   = GW'(r_prod[XW-1:SH]);
    assign rem_full  = r_digit - q_digit * GW'(ssq_pkg::HUNDRED);
    assign rem_digit = rem_full[RW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= i_start ? 4'b0001 : {r_phase[2:0], 1'b0};
            r_done  <= r_phase[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_digit <= i_dividend[W-1:LW];
            r_low   <= i_dividend[LW-1:0];
        end else if (r_phase[1]) begin
            r_digit <= {rem_digit, r_low};
        end
        if (r_phase[0] || r_phase[2]) begin
            r_prod <= XW'(r_digit) * XW'(RECIP);
        end
        if (r_phase[1]) begin
            r_qh <= q_digit;
        end
        if (r_phase[3]) begin
            r_ql  <= q_digit[LW-1:0];
            r_rem <= rem_digit;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = {r_qh, r_ql};
    assign o_remainder = r_rem;

endmodule

// File: hw/rtl/ssq_back.sv
module ssq_back #(
    parameter int MAX_SAMPLES = ssq_pkg::MAX_SAMPLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ssq_pkg::t_cmd                     i_head,
    input  ssq_pkg::t_q_flags                 i_q_flags,
    output logic                              o_pop,
    output logic                              o_result_strobe,
    output logic [1:0]                        o_status,
    output logic                              o_set_valid,
    output logic [ssq_pkg::COUNT_OUT_W-1:0]   o_sample_count,
    output logic signed [ssq_pkg::DATA_W-1:0] o_minimum_value,
    output logic signed [ssq_pkg::DATA_W-1:0] o_tenth_percentile,
    output logic signed [ssq_pkg::DATA_W-1:0] o_median_value,
    output logic signed [ssq_pkg::DATA_W-1:0] o_ninetieth_percentile,
    output logic signed [ssq_pkg::DATA_W-1:0] o_ninety_fifth_percentile,
    output logic signed [ssq_pkg::DATA_W-1:0] o_maximum_value
);

    localparam int DW  = ssq_pkg::DATA_W;
    localparam int PW  = ssq_pkg::PROD_W;
    localparam int FW  = ssq_pkg::FRAC_W;
    localparam int NQ  = ssq_pkg::NUM_Q;
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int AW  = $clog2(MAX_SAMPLES);
    localparam int QW  = $clog2(NQ);
    localparam int NMW = AW + FW;

    ssq_pkg::t_bstate r_state;
    ssq_pkg::t_bstate n_state;

    logic [DW-1:0]          r_mem [MAX_SAMPLES];
    logic [DW-1:0]          r_rdata;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [DW-1:0]          mem_wd;
    logic [AW-1:0]          rd_addr;

    ssq_pkg::t_cmd          r_cmd;
    ssq_pkg::t_cmd          n_cmd;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_nf;
    logic                   n_nf;
    logic                   r_ovf;
    logic                   n_ovf;
    logic [AW-1:0]          r_pos;
    logic [AW-1:0]          n_pos;
    logic [QW-1:0]          r_qi;
    logic [QW-1:0]          n_qi;
    logic [AW-1:0]          r_lower;
    logic [AW-1:0]          n_lower;
    logic [FW-1:0]          r_frac;
    logic [FW-1:0]          n_frac;
    logic [DW-1:0]          r_lo;
    logic [DW-1:0]          n_lo;
    logic [PW-1:0]          r_prod;
    logic [PW-1:0]          n_prod;
    ssq_pkg::t_status       r_status;
    ssq_pkg::t_status       n_status;
    logic                   r_set_valid;
    logic                   n_set_valid;
    logic [ssq_pkg::COUNT_OUT_W-1:0] r_out_count;
    logic [ssq_pkg::COUNT_OUT_W-1:0] n_out_count;
    logic [DW-1:0]          r_min;
    logic [DW-1:0]          n_min;
    logic [DW-1:0]          r_max;
    logic [DW-1:0]          n_max;
    logic [DW-1:0]          r_q [NQ];
    logic [DW-1:0]          n_q [NQ];

    logic                   div_start;
    logic [PW-1:0]          div_dividend;
    logic                   div_done;
    logic [PW-1:0]          div_quot;
    logic [FW-1:0]          div_rem;

    logic                   greater;
    logic                   set_ok;
    logic [AW-1:0]          last_idx;
    logic [NMW-1:0]         num;
    logic [DW-1:0]          diff;

    assign greater  = $signed(r_rdata) > $signed(r_cmd.value);
    assign set_ok   = !r_nf && !r_ovf;
    assign last_idx = AW'(r_count - 1'b1);
    assign num      = NMW'(ssq_pkg::PCT[r_qi]) * NMW'(last_idx);
    assign diff     = r_rdata - r_lo;

    ssq_div100 u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .o_done      (div_done),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ssq_pkg::B_IDLE: begin
                if (!i_q_flags.empty) begin
                    n_state = ssq_pkg::B_EXEC;
                end
            end
            ssq_pkg::B_EXEC: begin
                if (r_cmd.kind == ssq_pkg::K_INSERT && r_count != '0) begin
                    n_state = ssq_pkg::B_INS_CMP;
                end else if (r_cmd.last) begin
                    n_state = ssq_pkg::B_CLOSE;
                end else begin
                    n_state = ssq_pkg::B_IDLE;
                end
            end
            ssq_pkg::B_INS_CMP: begin
                if (greater) begin
                    if (r_pos == AW'(1)) begin
                        n_state = ssq_pkg::B_INS_WR;
                    end
                end else if (r_cmd.last) begin
                    n_state = ssq_pkg::B_CLOSE;
                end else begin
                    n_state = ssq_pkg::B_IDLE;
                end
            end
            ssq_pkg::B_INS_WR: begin
                n_state = r_cmd.last ? ssq_pkg::B_CLOSE : ssq_pkg::B_IDLE;
            end
            ssq_pkg::B_CLOSE: begin
                n_state = (set_ok && r_count != '0) ? ssq_pkg::B_MIN : ssq_pkg::B_OUT;
            end
            ssq_pkg::B_MIN: begin
                n_state = ssq_pkg::B_MAX;
            end
            ssq_pkg::B_MAX: begin
                n_state = ssq_pkg::B_Q_NUM;
            end
            ssq_pkg::B_Q_NUM: begin
                n_state = ssq_pkg::B_Q_DIV1;
            end
            ssq_pkg::B_Q_DIV1: begin
                if (div_done) begin
                    n_state = ssq_pkg::B_Q_LO;
                end
            end
            ssq_pkg::B_Q_LO: begin
                n_state = ssq_pkg::B_Q_HI;
            end
            ssq_pkg::B_Q_HI: begin
                if (r_frac != '0) begin
                    n_state = ssq_pkg::B_Q_DIV2S;
                end else if (r_qi == QW'(NQ - 1)) begin
                    n_state = ssq_pkg::B_OUT;
                end else begin
                    n_state = ssq_pkg::B_Q_NUM;
                end
            end
            ssq_pkg::B_Q_DIV2S: begin
                n_state = ssq_pkg::B_Q_DIV2;
            end
            ssq_pkg::B_Q_DIV2: begin
                if (div_done) begin
                    n_state = (r_qi == QW'(NQ - 1)) ? ssq_pkg::B_OUT : ssq_pkg::B_Q_NUM;
                end
            end
            ssq_pkg::B_OUT: begin
                n_state = ssq_pkg::B_IDLE;
            end
            default: begin
                n_state = ssq_pkg::B_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = r_pos;
        mem_wd       = r_cmd.value;
        rd_addr      = '0;
        div_start    = 1'b0;
        div_dividend = r_prod;
        n_cmd        = r_cmd;
        n_count      = r_count;
        n_nf         = r_nf;
        n_ovf        = r_ovf;
        n_pos        = r_pos;
        n_qi         = r_qi;
        n_lower      = r_lower;
        n_frac       = r_frac;
        n_lo         = r_lo;
        n_prod       = r_prod;
        n_status     = r_status;
        n_set_valid  = r_set_valid;
        n_out_count  = r_out_count;
        n_min        = r_min;
        n_max        = r_max;
        n_q          = r_q;
        case (r_state)
            ssq_pkg::B_IDLE: begin
                if (!i_q_flags.empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_head;
                end
            end
            ssq_pkg::B_EXEC: begin
                case (r_cmd.kind)
                    ssq_pkg::K_NON_FINITE: begin
                        n_nf = 1'b1;
                    end
                    ssq_pkg::K_OVERFLOW: begin
                        n_ovf = 1'b1;
                    end
                    ssq_pkg::K_INSERT: begin
                        if (r_count == '0) begin
                            mem_we  = 1'b1;
                            mem_wa  = '0;
                            n_count = r_count + 1'b1;
                        end else begin
                            rd_addr = last_idx;
                            n_pos   = AW'(r_count);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ssq_pkg::B_INS_CMP: begin
                mem_we = 1'b1;
                if (greater) begin
                    mem_wd  = r_rdata;
                    n_pos   = r_pos - 1'b1;
                    rd_addr = r_pos - AW'(2);
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            ssq_pkg::B_INS_WR: begin
                mem_we  = 1'b1;
                mem_wa  = '0;
                n_count = r_count + 1'b1;
            end
            ssq_pkg::B_CLOSE: begin
                if (r_nf) begin
                    n_status = ssq_pkg::ST_NON_FINITE;
                end else if (r_ovf) begin
                    n_status = ssq_pkg::ST_OVERFLOW;
                end else begin
                    n_status = ssq_pkg::ST_OK;
                end
                n_set_valid = set_ok && r_count != '0;
                n_out_count = set_ok ? ssq_pkg::COUNT_OUT_W'(r_count) : '0;
                n_min       = '0;
                n_max       = '0;
                for (int i = 0; i < NQ; i++) begin
                    n_q[i] = '0;
                end
                rd_addr = '0;
            end
            ssq_pkg::B_MIN: begin
                n_min   = r_rdata;
                rd_addr = last_idx;
            end
            ssq_pkg::B_MAX: begin
                n_max = r_rdata;
                n_qi  = '0;
            end
            ssq_pkg::B_Q_NUM: begin
                div_start    = 1'b1;
                div_dividend = PW'(num);
            end
            ssq_pkg::B_Q_DIV1: begin
                if (div_done) begin
                    n_lower = div_quot[AW-1:0];
                    n_frac  = div_rem;
                    rd_addr = div_quot[AW-1:0];
                end
            end
            ssq_pkg::B_Q_LO: begin
                n_lo    = r_rdata;
                rd_addr = r_lower + 1'b1;
            end
            ssq_pkg::B_Q_HI: begin
                if (r_frac != '0) begin
                    n_prod = PW'(r_frac) * PW'(diff);
                end else begin
                    n_q[r_qi] = r_lo;
                    if (r_qi != QW'(NQ - 1)) begin
                        n_qi = r_qi + 1'b1;
                    end
                end
            end
            ssq_pkg::B_Q_DIV2S: begin
                div_start = 1'b1;
            end
            ssq_pkg::B_Q_DIV2: begin
                if (div_done) begin
                    n_q[r_qi] = r_lo + div_quot[DW-1:0];
                    if (r_qi != QW'(NQ - 1)) begin
                        n_qi = r_qi + 1'b1;
                    end
                end
            end
            ssq_pkg::B_OUT: begin
                n_count = '0;
                n_nf    = 1'b0;
                n_ovf   = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssq_pkg::B_IDLE;
            r_count <= '0;
            r_nf    <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_nf    <= n_nf;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_pos       <= n_pos;
        r_qi        <= n_qi;
        r_lower     <= n_lower;
        r_frac      <= n_frac;
        r_lo        <= n_lo;
        r_prod      <= n_prod;
        r_status    <= n_status;
        r_set_valid <= n_set_valid;
        r_out_count <= n_out_count;
        r_min       <= n_min;
        r_max       <= n_max;
        r_q         <= n_q;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign o_result_strobe           = (r_state == ssq_pkg::B_OUT);
    assign o_status                  = r_status;
    assign o_set_valid               = r_set_valid;
    assign o_sample_count            = r_out_count;
    assign o_minimum_value           = r_min;
    assign o_tenth_percentile        = r_q[0];
    assign o_median_value            = r_q[1];
    assign o_ninetieth_percentile    = r_q[2];
    assign o_ninety_fifth_percentile = r_q[3];
    assign o_maximum_value           = r_max;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SAMPLES))
        else $error("sample store holds more entries than it has room for");

    a_valid_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && o_set_valid |->
            o_status == ssq_pkg::ST_OK &&
            $signed(o_minimum_value) <= $signed(o_median_value) &&
            $signed(o_median_value) <= $signed(o_maximum_value))
        else $error("valid result is not ordered or has error status");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && o_status != ssq_pkg::ST_OK |->
            !o_set_valid && o_sample_count == '0 && o_minimum_value == '0 &&
            o_maximum_value == '0)
        else $error("error result carries non-zero fields");

    a_set_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> r_count == '0 && !r_nf && !r_ovf)
        else $error("set state not cleared after a result");

    a_insert_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ssq_pkg::B_INS_CMP |-> r_pos != '0 && r_cmd.kind == ssq_pkg::K_INSERT)
        else $error("insertion walk reached an invalid position");

endmodule

// File: hw/rtl/sorted_sample_quantiles.sv
// Sample requests are taken whenever busy is low, one per clock, into a four-entry queue; busy
// rises only when that queue is full. Each sample is sorted into a store with one write and one
// read port by walking down from the top, moving every stored sample larger than it up by one
// place. Closing a set reads the extremes and then computes the four percentiles one after
// another through one shared divide-by-100 unit: a percentile that falls between two samples
// needs a second division to interpolate between them, one that falls on a stored sample does
// not; a set with an error or with no samples skips these steps and gives its result straight
// from the close. The result is shown for exactly one clock with o_result_strobe high and
// cannot be held off by the receiver, so it must be captured in that cycle.
module sorted_sample_quantiles #(
    parameter int MAX_SAMPLES = ssq_pkg::MAX_SAMPLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_has_sample,
    input  logic signed [ssq_pkg::DATA_W-1:0] i_sample_value,
    input  logic                              i_sample_not_finite,
    input  logic                              i_last_of_set,
    output logic                              o_result_strobe,
    output logic [1:0]                        o_status,
    output logic                              o_set_valid,
    output logic [ssq_pkg::COUNT_OUT_W-1:0]   o_sample_count,
    output logic signed [ssq_pkg::DATA_W-1:0] o_minimum_value,
    output logic signed [ssq_pkg::DATA_W-1:0] o_tenth_percentile,
    output logic signed [ssq_pkg::DATA_W-1:0] o_median_value,
    output logic signed [ssq_pkg::DATA_W-1:0] o_ninetieth_percentile,
    output logic signed [ssq_pkg::DATA_W-1:0] o_ninety_fifth_percentile,
    output logic signed [ssq_pkg::DATA_W-1:0] o_maximum_value
);

    ssq_pkg::t_q_flags q_flags;
    ssq_pkg::t_cmd     push_cmd;
    ssq_pkg::t_cmd     head_cmd;
    logic              push;
    logic              pop;

    ssq_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (start),
        .i_has_sample        (i_has_sample),
        .i_sample_value      (i_sample_value),
        .i_sample_not_finite (i_sample_not_finite),
        .i_last_of_set       (i_last_of_set),
        .i_q_flags           (q_flags),
        .o_busy              (busy),
        .o_push              (push),
        .o_cmd               (push_cmd)
    );

    ssq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_flags (q_flags)
    );

    ssq_back #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_head                    (head_cmd),
        .i_q_flags                 (q_flags),
        .o_pop                     (pop),
        .o_result_strobe           (o_result_strobe),
        .o_status                  (o_status),
        .o_set_valid               (o_set_valid),
        .o_sample_count            (o_sample_count),
        .o_minimum_value           (o_minimum_value),
        .o_tenth_percentile        (o_tenth_percentile),
        .o_median_value            (o_median_value),
        .o_ninetieth_percentile    (o_ninetieth_percentile),
        .o_ninety_fifth_percentile (o_ninety_fifth_percentile),
        .o_maximum_value           (o_maximum_value)
    );

endmodule
